// ===== src/hcm_pkg.sv =====
// hcm_pkg: shared types, constants and the divider step for the hsv color match unit
`timescale 1ns / 1ps

package hcm_pkg;

  localparam int CH_W    = 8;   // rgb channel, saturation and value width
  localparam int HUE_W   = 9;
  localparam int TOL_W   = 9;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 4;

  // pipelined long divider: 16-bit dividend, 8-bit divisor, 8-bit quotient
  localparam int DIV_DVD_W = 16;
  localparam int DIV_Q_W   = 8;
  localparam int DIV_STG   = 4;
  localparam int DIV_STEPS = DIV_Q_W / DIV_STG;

  // stage 0 rgb analysis, 1 dividends, 2..5 divider, 6 hsv, 7 squares, 8 output
  localparam int PIPE_STG  = 9;
  localparam int DIV_FIRST = 2;
  localparam int HSV_STG   = DIV_FIRST + DIV_STG;
  localparam int SQ_STG    = HSV_STG + 1;
  localparam int OUT_STG   = SQ_STG + 1;

  localparam int HUE_A_W   = 14;  // 60*|offset| + delta - 1 stays below 2**14
  localparam int HS_W      = 10;  // signed hue before wrap
  localparam int SQ_H_W    = 18;
  localparam int SQ_C_W    = 16;
  localparam int DIST_W    = 23;

  localparam logic [CH_W-1:0]    MIN_LEVEL  = 8'd10;
  localparam logic [HUE_A_W-1:0] SECTOR_DEG = 14'd60;
  localparam logic [HS_W-1:0]    HUE_R_BASE = 10'd0;
  localparam logic [HS_W-1:0]    HUE_G_BASE = 10'd120;
  localparam logic [HS_W-1:0]    HUE_B_BASE = 10'd240;
  localparam logic [HS_W-1:0]    HUE_WRAP   = 10'd360;

  localparam logic [HUE_W-1:0] RST_HUE = 9'd240;
  localparam logic [CH_W-1:0]  RST_SAT = 8'd212;
  localparam logic [CH_W-1:0]  RST_VAL = 8'd60;
  localparam logic [TOL_W-1:0] RST_TOL = 9'd30;

  typedef enum logic [1:0] {
    REG_HUE = 2'd0,
    REG_SAT = 2'd1,
    REG_VAL = 2'd2,
    REG_TOL = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    SEC_R = 2'd0,
    SEC_G = 2'd1,
    SEC_B = 2'd2
  } sector_t;

  typedef struct packed {
    logic [CH_W-1:0] mx;
    logic            grey;
    sector_t         sector;
    logic            neg;
  } side_t;

  typedef struct packed {
    logic [DIV_Q_W-1:0] rem;
    logic [DIV_Q_W-1:0] low;
    logic [DIV_Q_W-1:0] quo;
  } div_st_t;

  // a few restoring division steps, one quotient bit each
  function automatic div_st_t div_step(div_st_t s, logic [DIV_Q_W-1:0] d);
    div_st_t          st;
    logic [DIV_Q_W:0] r9;
    st = s;
    for (int i = 0; i < DIV_STEPS; i++) begin
      r9     = {st.rem, st.low[DIV_Q_W-1]};
      st.low = {st.low[DIV_Q_W-2:0], 1'b0};
      if (r9 >= {1'b0, d}) begin
        r9     = r9 - {1'b0, d};
        st.quo = {st.quo[DIV_Q_W-2:0], 1'b1};
      end else begin
        st.quo = {st.quo[DIV_Q_W-2:0], 1'b0};
      end
      st.rem = r9[DIV_Q_W-1:0];
    end
    return st;
  endfunction

endpackage

// ===== src/hcm_pix_if.sv =====
// hcm_pix_if: rgb pixel channel with valid/ready handshake
`timescale 1ns / 1ps

interface hcm_pix_if import hcm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

// ===== src/hcm_res_if.sv =====
// hcm_res_if: hsv and match result channel with valid/ready handshake
`timescale 1ns / 1ps

interface hcm_res_if import hcm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             is_match;
  logic [HUE_W-1:0] pixel_hue;
  logic [CH_W-1:0]  pixel_saturation;
  logic [CH_W-1:0]  pixel_brightness;

  modport source (output valid, is_match, pixel_hue, pixel_saturation, pixel_brightness,
                  input ready);
  modport sink   (input valid, is_match, pixel_hue, pixel_saturation, pixel_brightness,
                  output ready);
endinterface

// ===== src/hsv_color_match_unit.sv =====
// hsv_color_match_unit: rgb to hsv conversion and weighted match against a learned color
//
// Takes one rgb pixel per clock while in.ready is high and returns one result per pixel,
// in order. The pipeline has nine register stages: rgb analysis, dividend forming, four
// divider stages (two quotient bits each, shared shape for saturation and hue), hsv
// assembly, squaring and the final compare. Stalls on the output back up stage by stage,
// and bubbles are squeezed out, so in.ready stays high while any stage is empty. The
// learned hue, saturation, brightness and tolerance sit in four apb registers at byte
// addresses 0, 4, 8 and 12; write them only while no pixel is in flight.
`timescale 1ns / 1ps

module hsv_color_match_unit import hcm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  hcm_pix_if.sink           in_pix,
  hcm_res_if.source         out_res,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  // ---------------- configuration registers ----------------
  logic [HUE_W-1:0] lhue_r;
  logic [CH_W-1:0]  lsat_r;
  logic [CH_W-1:0]  lval_r;
  logic [TOL_W-1:0] tol_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lhue_r <= RST_HUE;
      lsat_r <= RST_SAT;
      lval_r <= RST_VAL;
      tol_r  <= RST_TOL;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_HUE: lhue_r <= cfg_pwdata[HUE_W-1:0];
        REG_SAT: lsat_r <= cfg_pwdata[CH_W-1:0];
        REG_VAL: lval_r <= cfg_pwdata[CH_W-1:0];
        REG_TOL: tol_r  <= cfg_pwdata[TOL_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_HUE: cfg_prdata = {{(APB_DW-HUE_W){1'b0}}, lhue_r};
      REG_SAT: cfg_prdata = {{(APB_DW-CH_W){1'b0}}, lsat_r};
      REG_VAL: cfg_prdata = {{(APB_DW-CH_W){1'b0}}, lval_r};
      REG_TOL: cfg_prdata = {{(APB_DW-TOL_W){1'b0}}, tol_r};
    endcase
  end

  // ---------------- pipeline control ----------------
  logic [PIPE_STG-1:0] v_r;
  logic [PIPE_STG-1:0] en;

  always_comb begin
    en[PIPE_STG-1] = !v_r[PIPE_STG-1] | out_res.ready;
    for (int k = PIPE_STG - 2; k >= 0; k--) begin
      en[k] = !v_r[k] | en[k+1];
    end
  end

  assign in_pix.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_pix.valid;
      end
      for (int k = 1; k < PIPE_STG; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // ---------------- stage 0: max, min, sector, offset ----------------
  logic [CH_W-1:0]   r, g, b, mx, mn;
  logic signed [CH_W:0] s_diff;
  side_t             side_in;
  logic [CH_W-1:0]   sabs_in;
  side_t             side_r [HSV_STG];
  logic [CH_W-1:0]   delta0_r;
  logic [CH_W-1:0]   sabs0_r;

  always_comb begin
    r  = in_pix.red;
    g  = in_pix.green;
    b  = in_pix.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    // red wins a tie for the maximum, then green
    priority if (r == mx) begin
      side_in.sector = SEC_R;
      s_diff = $signed({1'b0, g}) - $signed({1'b0, b});
    end else if (g == mx) begin
      side_in.sector = SEC_G;
      s_diff = $signed({1'b0, b}) - $signed({1'b0, r});
    end else begin
      side_in.sector = SEC_B;
      s_diff = $signed({1'b0, r}) - $signed({1'b0, g});
    end
    side_in.mx   = mx;
    side_in.grey = (mx == mn);
    side_in.neg  = s_diff[CH_W];
    sabs_in      = s_diff[CH_W] ? CH_W'(-s_diff) : s_diff[CH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side_r[0] <= side_in;
      delta0_r  <= mx - mn;
      sabs0_r   <= sabs_in;
    end
  end

  // ---------------- stage 1: dividends ----------------
  logic [DIV_DVD_W-1:0] satn1_r;
  logic [DIV_DVD_W-1:0] huea1_r;
  logic [CH_W-1:0]      delta1_r;
  logic [HUE_A_W-1:0]   hue_a;

  // negative offsets round toward minus infinity: ceil via adding delta - 1
  always_comb begin
    hue_a = HUE_A_W'({{(HUE_A_W-CH_W){1'b0}}, sabs0_r} * SECTOR_DEG);
    if (side_r[0].neg) begin
      hue_a = hue_a + {{(HUE_A_W-CH_W){1'b0}}, delta0_r} - HUE_A_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      side_r[1] <= side_r[0];
      satn1_r   <= {delta0_r, {CH_W{1'b0}}} - {{CH_W{1'b0}}, delta0_r};
      huea1_r   <= {{(DIV_DVD_W-HUE_A_W){1'b0}}, hue_a};
      delta1_r  <= delta0_r;
    end
  end

  // ---------------- stages 2..5: dividers ----------------
  logic [DIV_Q_W-1:0] q_sat;
  logic [DIV_Q_W-1:0] q_hue;

  hcm_div u_div_sat (
    .clk      (clk),
    .en       (en[HSV_STG-1:DIV_FIRST]),
    .dividend (satn1_r),
    .divisor  (side_r[1].mx),
    .quotient (q_sat)
  );

  hcm_div u_div_hue (
    .clk      (clk),
    .en       (en[HSV_STG-1:DIV_FIRST]),
    .dividend (huea1_r),
    .divisor  (delta1_r),
    .quotient (q_hue)
  );

  always_ff @(posedge clk) begin
    for (int k = DIV_FIRST; k < HSV_STG; k++) begin
      if (en[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // ---------------- stage 6: hsv assembly ----------------
  side_t                side_d;
  logic signed [HS_W-1:0] hue_s;
  logic [HS_W-1:0]      base;
  logic [HS_W-1:0]      q_ext;
  logic [HUE_W-1:0]     hue6_r;
  logic [CH_W-1:0]      sat6_r;
  logic [CH_W-1:0]      val6_r;

  always_comb begin
    side_d = side_r[HSV_STG-1];
    q_ext  = {{(HS_W-DIV_Q_W){1'b0}}, q_hue};
    unique case (side_d.sector)
      SEC_R:   base = HUE_R_BASE;
      SEC_G:   base = HUE_G_BASE;
      SEC_B:   base = HUE_B_BASE;
      default: base = HUE_R_BASE;
    endcase
    hue_s = side_d.neg ? $signed(base - q_ext) : $signed(base + q_ext);
    if (hue_s < 0) begin
      hue_s = hue_s + $signed(HUE_WRAP);
    end
  end

  always_ff @(posedge clk) begin
    if (en[HSV_STG]) begin
      // grey covers black too; black also has no defined saturation
      hue6_r <= side_d.grey ? '0 : hue_s[HUE_W-1:0];
      sat6_r <= (side_d.mx == '0) ? '0 : q_sat;
      val6_r <= side_d.mx;
    end
  end

  // ---------------- stage 7: squared differences ----------------
  logic signed [HS_W-1:0] dh;
  logic signed [CH_W:0]   ds, dv;
  logic [HUE_W-1:0]       adh;
  logic [CH_W-1:0]        ads, adv;
  logic [SQ_H_W-1:0]      sqh7_r, sqt7_r;
  logic [SQ_C_W-1:0]      sqs7_r, sqv7_r;
  logic                   lvl7_r;
  logic [HUE_W-1:0]       hue7_r;
  logic [CH_W-1:0]        sat7_r;
  logic [CH_W-1:0]        val7_r;

  // differences are not wrapped around the hue circle
  always_comb begin
    dh  = $signed({1'b0, hue6_r}) - $signed({1'b0, lhue_r});
    ds  = $signed({1'b0, sat6_r}) - $signed({1'b0, lsat_r});
    dv  = $signed({1'b0, val6_r}) - $signed({1'b0, lval_r});
    adh = dh[HS_W-1] ? HUE_W'(-dh) : dh[HUE_W-1:0];
    ads = ds[CH_W]   ? CH_W'(-ds)  : ds[CH_W-1:0];
    adv = dv[CH_W]   ? CH_W'(-dv)  : dv[CH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[SQ_STG]) begin
      sqh7_r <= adh * adh;
      sqt7_r <= tol_r * tol_r;
      sqs7_r <= ads * ads;
      sqv7_r <= adv * adv;
      lvl7_r <= (val6_r > MIN_LEVEL) && (sat6_r > MIN_LEVEL);
      hue7_r <= hue6_r;
      sat7_r <= sat6_r;
      val7_r <= val6_r;
    end
  end

  // ---------------- stage 8: weighted distance compare ----------------
  logic [DIST_W-1:0] wdist;
  logic [DIST_W-1:0] lim;
  logic              match8_r;
  logic [HUE_W-1:0]  hue8_r;
  logic [CH_W-1:0]   sat8_r;
  logic [CH_W-1:0]   val8_r;

  always_comb begin
    wdist = DIST_W'({sqh7_r, 4'b0000}) + DIST_W'({sqs7_r, 2'b00}) + DIST_W'(sqv7_r);
    lim   = DIST_W'({sqt7_r, 4'b0000});
  end

  always_ff @(posedge clk) begin
    if (en[OUT_STG]) begin
      match8_r <= lvl7_r && (wdist <= lim);
      hue8_r   <= hue7_r;
      sat8_r   <= sat7_r;
      val8_r   <= val7_r;
    end
  end

  assign out_res.valid            = v_r[OUT_STG];
  assign out_res.is_match         = match8_r;
  assign out_res.pixel_hue        = hue8_r;
  assign out_res.pixel_saturation = sat8_r;
  assign out_res.pixel_brightness = val8_r;

endmodule

// ===== src/hcm_div.sv =====
// hcm_div: pipelined restoring divider, two quotient bits per stage
`timescale 1ns / 1ps

module hcm_div import hcm_pkg::*; (
  input  logic                 clk,
  input  logic [DIV_STG-1:0]   en,
  input  logic [DIV_DVD_W-1:0] dividend,
  input  logic [DIV_Q_W-1:0]   divisor,
  output logic [DIV_Q_W-1:0]   quotient
);

  div_st_t            st_r [DIV_STG];
  logic [DIV_Q_W-1:0] d_r  [DIV_STG];
  div_st_t            st_in [DIV_STG];
  logic [DIV_Q_W-1:0] d_in  [DIV_STG];

  // quotient fits in 8 bits, so the upper dividend half is already below the divisor
  always_comb begin
    st_in[0].rem = dividend[DIV_DVD_W-1:DIV_Q_W];
    st_in[0].low = dividend[DIV_Q_W-1:0];
    st_in[0].quo = '0;
    d_in[0]      = divisor;
    for (int k = 1; k < DIV_STG; k++) begin
      st_in[k] = st_r[k-1];
      d_in[k]  = d_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STG; k++) begin
      if (en[k]) begin
        st_r[k] <= div_step(st_in[k], d_in[k]);
        d_r[k]  <= d_in[k];
      end
    end
  end

  assign quotient = st_r[DIV_STG-1].quo;

endmodule

// ===== tb/sv/hcm_match_checker.sv =====
// hcm_match_checker: predicts hsv results and match flags and compares them with the result channel
`timescale 1ns / 1ps

module hcm_match_checker import hcm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  hcm_pix_if                pix,
  hcm_res_if                res,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  input  logic              cfg_pready,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic             is_match;
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  sat;
    logic [CH_W-1:0]  val;
  } hsv_result_t;

  localparam int LEVEL_FLOOR = 10;

  logic [HUE_W-1:0] ref_hue_q;
  logic [CH_W-1:0]  ref_sat_q;
  logic [CH_W-1:0]  ref_val_q;
  logic [TOL_W-1:0] tol_q;

  hsv_result_t hsv_expected_q[$];

  function automatic hsv_result_t convert_pixel(logic [CH_W-1:0] r8, logic [CH_W-1:0] g8,
                                                logic [CH_W-1:0] b8);
    int          r, g, b, mx, mn, delta, num, hue, sat, dh, ds, dv, tol;
    hsv_result_t pred;
    r = int'(r8);
    g = int'(g8);
    b = int'(b8);
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    hue = 0;
    sat = 0;
    if (mx != 0) begin
      sat = (delta * 255) / mx;
      if (delta != 0) begin
        // red wins a tie for the maximum, then green
        if (r == mx) begin
          num = 60 * (g - b);
        end else if (g == mx) begin
          num = 120 * delta + 60 * (b - r);
        end else begin
          num = 240 * delta + 60 * (r - g);
        end
        // floor, not truncation, for negative offsets
        hue = num / delta;
        if ((num % delta) != 0 && num < 0) hue = hue - 1;
        if (hue < 0) hue = hue + 360;
      end
    end
    pred.is_match = 1'b0;
    if (mx > LEVEL_FLOOR && sat > LEVEL_FLOOR) begin
      // hue difference is not wrapped around the circle
      dh  = hue - int'(ref_hue_q);
      ds  = sat - int'(ref_sat_q);
      dv  = mx - int'(ref_val_q);
      tol = int'(tol_q);
      pred.is_match = (16 * dh * dh + 4 * ds * ds + dv * dv) <= 16 * tol * tol;
    end
    pred.hue = hue[HUE_W-1:0];
    pred.sat = sat[CH_W-1:0];
    pred.val = mx[CH_W-1:0];
    return pred;
  endfunction

  task automatic report(string msg);
    $display("checker: %s", msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    hsv_result_t want;
    if (!rst_n) begin
      ref_hue_q  = 9'd240;
      ref_sat_q  = 8'd212;
      ref_val_q  = 8'd60;
      tol_q      = 9'd30;
      hsv_expected_q.delete();
      fail_count = 0;
      pending    = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (hsv_expected_q.size() == 0) begin
          report("result item with nothing expected");
        end else begin
          want = hsv_expected_q.pop_front();
          if (res.is_match !== want.is_match)
            report($sformatf("is_match got %0d expected %0d", res.is_match, want.is_match));
          if (res.pixel_hue !== want.hue)
            report($sformatf("pixel_hue got %0d expected %0d", res.pixel_hue, want.hue));
          if (res.pixel_saturation !== want.sat)
            report($sformatf("pixel_saturation got %0d expected %0d",
                             res.pixel_saturation, want.sat));
          if (res.pixel_brightness !== want.val)
            report($sformatf("pixel_brightness got %0d expected %0d",
                             res.pixel_brightness, want.val));
        end
      end
      if (pix.valid && pix.ready)
        hsv_expected_q.push_back(convert_pixel(pix.red, pix.green, pix.blue));
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[3:2]))
          REG_HUE: ref_hue_q = cfg_pwdata[HUE_W-1:0];
          REG_SAT: ref_sat_q = cfg_pwdata[CH_W-1:0];
          REG_VAL: ref_val_q = cfg_pwdata[CH_W-1:0];
          REG_TOL: tol_q     = cfg_pwdata[TOL_W-1:0];
          default: ;
        endcase
      end
      pending = hsv_expected_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: pixel and register stimulus for the hsv color match unit, with the run verdict
`timescale 1ns / 1ps

module tb_top import hcm_pkg::*; ();

  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 136;
  localparam int HOLD_CYCLES  = 150;
  localparam int TAIL_CYCLES  = 20;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int   fail_count;
  int   pending;
  int   cycle_count;
  bit   idle_on;
  bit   hold_req;
  int   hold_left;
  int   stall_left;
  logic pix_fire_q;
  logic apb_fire_q;

  hcm_pix_if pix_if ();
  hcm_res_if res_if ();

  hsv_color_match_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_pix      (pix_if),
    .out_res     (res_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  hcm_match_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pix         (pix_if),
    .res         (res_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // handshakes seen at the rising edge, read back at the following falling edge
  always @(posedge clk) begin
    pix_fire_q <= pix_if.valid && pix_if.ready;
    apb_fire_q <= cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  end

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [CH_W-1:0] rand_chan();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic cfg_write(reg_idx_t idx, int unsigned value, int unsigned mask);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    // upper bits are noise the register must drop
    cfg_pwdata  = (value & mask) | ($urandom & ~mask);
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(negedge clk); while (!apb_fire_q);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic load_color(int unsigned hue, int unsigned sat, int unsigned val,
                            int unsigned tol);
    cfg_write(REG_HUE, hue, 32'h1ff);
    cfg_write(REG_SAT, sat, 32'hff);
    cfg_write(REG_VAL, val, 32'hff);
    cfg_write(REG_TOL, tol, 32'h1ff);
  endtask

  task automatic send_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
    pix_if.valid = 1'b1;
    pix_if.red   = r;
    pix_if.green = g;
    pix_if.blue  = b;
    do @(negedge clk); while (!pix_fire_q);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      pix_if.valid = 1'b0;
      pix_if.red   = rand_chan();
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
  endtask

  task automatic send_random_pixel();
    logic [CH_W-1:0] r, g, b;
    r = rand_chan();
    g = rand_chan();
    b = rand_chan();
    // ties for the maximum and grey pixels
    case ($urandom_range(0, 11))
      0: g = r;
      1: b = r;
      2: b = g;
      3: begin
        g = r;
        b = r;
      end
      default: ;
    endcase
    send_pixel(r, g, b);
  endtask

  // stop offering the last item before waiting for the results
  task automatic drain();
    pix_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // result side: random stall bursts, and a long hold on request
  initial begin
    hold_left  = 0;
    stall_left = 0;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        res_if.ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        res_if.ready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        res_if.ready = 1'b0;
        stall_left   = $urandom_range(1, 9) - 1;
      end else begin
        res_if.ready = 1'b1;
      end
    end
  end

  initial begin
    int phase;
    int n;
    rst_n        = 1'b0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    pix_if.valid = 1'b0;
    pix_if.red   = '0;
    pix_if.green = '0;
    pix_if.blue  = '0;
    res_if.ready = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset colour: black, white, grey, primaries, ties, negative hue offset
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd200, 8'd200, 8'd50);
    send_pixel(8'd50, 8'd200, 8'd200);
    send_pixel(8'd200, 8'd50, 8'd200);
    send_pixel(8'd255, 8'd0, 8'd10);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    // brightness and saturation floor on both sides
    send_pixel(8'd10, 8'd0, 8'd0);
    send_pixel(8'd11, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd245, 8'd245);
    send_pixel(8'd255, 8'd244, 8'd244);
    // close to the reset colour
    send_pixel(8'd10, 8'd10, 8'd60);
    send_pixel(8'd20, 8'd12, 8'd70);
    send_pixel(8'd40, 8'd10, 8'd90);
    drain();
    // zero tolerance: only an exact hit matches
    load_color(240, 212, 60, 0);
    send_pixel(8'd10, 8'd10, 8'd60);
    send_pixel(8'd10, 8'd10, 8'd61);
    send_pixel(8'd10, 8'd11, 8'd60);

    for (phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0:       load_color(0, 0, 0, 0);
        1:       load_color(359, 255, 255, 400);
        2:       load_color(511, 255, 255, 511);
        3:       load_color(120, 128, 128, 511);
        default: load_color($urandom_range(0, 511), $urandom_range(0, 255),
                            $urandom_range(0, 255), $urandom_range(0, 511));
      endcase
      idle_on = !(phase == 4 || phase == 8 || phase == PHASES - 1);
      if (phase == 4) hold_req = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) send_random_pixel();
    end
    pix_if.valid = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
